// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker module.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on the rising edge, off during reset.
`define ZSN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("zsn assertion failed");

// Implication into the following cycle.
`define ZSN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("zsn assertion failed");

`endif

// ----- hw/rtl/zsn_pkg.sv -----
// Types and constants for the column z-score normaliser.
// Depends on nothing; used by the top, zsn_rootdiv and zsn_checker.
package zsn_pkg;

  localparam int MaxRows = 64;          // default column depth
  localparam int SampleW = 16;          // Q7.8 sample
  localparam int ScoreW  = 16;          // Q4.11 score
  localparam int SumW    = 23;          // running sum of a column
  localparam int DevW    = 24;          // signed n*x - S
  localparam int DsqW    = 2 * (DevW - 1);
  localparam int RootW   = 16;          // integer square root of the quotient
  localparam int QuoW    = 2 * RootW;   // quotient floor(2^24 n d^2 / Q)
  localparam int LowShift = 24;         // 2^24 scale of the dividend

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      column_end;
  } in_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic                     last_score;
  } out_t;

endpackage

// ----- hw/rtl/column_zscore_normalizer.sv -----
// Column z-score normaliser.
// Request channel: a sample is taken at a rising edge where start is high and
// busy is low. Samples of one column are stored in order; the sample with
// column_end set, or the MAX_ROWS-th sample, closes the column.
// Loading takes one sample per cycle while start is high and gives no result.
// On a close the block raises busy and makes two passes over the store:
//   variance pass: read, deviation, square, accumulate for each sample;
//   score pass: read, deviation, square, unit start, the shared divide/root
//   unit (32 division steps, 16 root steps, then the hand-back of the root)
//   and output, for each sample.
// A sample whose own or column deviation is zero skips the unit and scores zero.
// Each score appears on res_o for one cycle with res_valid_o high, in
// arrival order; the last one carries last_score. The receiver cannot stall.
// busy falls with the last score, and the next sample may be taken then.
// Reset empties the column and clears the sequencer; store contents are
// left as they are and never read before being written.
// Uses zsn_pkg, zsn_store and zsn_rootdiv.
module column_zscore_normalizer #(
  parameter int MAX_ROWS = zsn_pkg::MaxRows
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  zsn_pkg::in_t  req_i,
  output logic          busy,
  output logic          res_valid_o,
  output zsn_pkg::out_t res_o
);

  localparam int AddrW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CntW  = $clog2(MAX_ROWS + 1);
  localparam int DevW  = zsn_pkg::DevW;
  localparam int DsqW  = zsn_pkg::DsqW;
  localparam int SumW  = zsn_pkg::SumW;
  localparam int NdW   = DsqW + CntW;
  localparam int QW    = DsqW + CntW;
  localparam int ScoreW = zsn_pkg::ScoreW;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DIF  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_RUN  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [CntW-1:0]          cnt_q, idx_q;
  logic signed [SumW-1:0]   sum_q;
  logic                     pass_q;
  logic signed [DevW-1:0]   d_q;
  logic [DsqW-1:0]          dsq_q;
  logic [QW-1:0]            q_q;
  logic                     zero_q;
  logic                     valid_q;
  zsn_pkg::out_t            out_q;

  logic                     take, close, at_last, unit_start, unit_done;
  logic [zsn_pkg::SampleW-1:0] rdata;
  logic [zsn_pkg::RootW-1:0] root;
  logic signed [DevW-1:0]   n_s, x_s, s_s, d_d;
  logic [DevW-2:0]          ad;
  logic [zsn_pkg::RootW:0]  k;
  logic signed [ScoreW-1:0] score_d;

  assign take    = start && !busy;
  assign close   = req_i.column_end || (cnt_q + 1'b1 == CntW'(MAX_ROWS));
  assign at_last = idx_q == cnt_q - 1'b1;
  assign busy    = state_q != S_LOAD;

  zsn_store #(
    .Depth (MAX_ROWS),
    .AddrW (AddrW),
    .DataW (zsn_pkg::SampleW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (take),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (req_i.sample),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign unit_start = (state_q == S_MUL) && pass_q && !(q_q == '0 || dsq_q == '0);

  // dividend n*d^2 is taken straight from the squared deviation
  zsn_rootdiv #(
    .NdW (NdW),
    .QW  (QW)
  ) u_rootdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .nd2_i   (NdW'(cnt_q) * NdW'(dsq_q)),
    .q_i     (q_q),
    .done_o  (unit_done),
    .root_o  (root)
  );

  // deviation n*x - S and its magnitude
  always_comb begin
    n_s = $signed({{(DevW-CntW){1'b0}}, cnt_q});
    x_s = {{(DevW-zsn_pkg::SampleW){rdata[zsn_pkg::SampleW-1]}}, rdata};
    s_s = {{(DevW-SumW){sum_q[SumW-1]}}, sum_q};
    d_d = n_s * x_s - s_s;
    ad  = d_q[DevW-1] ? (DevW-1)'(-d_q) : d_q[DevW-2:0];
  end

  // rounded score from the root: k = (r + 1) / 2, then sign and clamp
  always_comb begin
    k = ({1'b0, root} + 1'b1) >> 1;
    if (zero_q) begin
      score_d = '0;
    end else if (d_q[DevW-1]) begin
      score_d = ScoreW'(-k);
    end else if (k > (zsn_pkg::RootW+1)'(32767)) begin
      score_d = ScoreW'(32767);
    end else begin
      score_d = ScoreW'(k);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: if (take && close) state_d = S_RD;
      S_RD:   state_d = S_DIF;
      S_DIF:  state_d = S_SQR;
      S_SQR:  state_d = pass_q ? S_MUL : S_ACC;
      S_ACC:  state_d = S_RD;
      S_MUL:  state_d = unit_start ? S_RUN : S_EMIT;
      S_RUN:  if (unit_done) state_d = S_EMIT;
      S_EMIT: state_d = at_last ? S_LOAD : S_RD;
      default: state_d = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
      pass_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= state_q == S_EMIT;
      case (state_q)
        S_LOAD: begin
          if (take) begin
            cnt_q  <= cnt_q + 1'b1;
            sum_q  <= sum_q + SumW'(req_i.sample);
            idx_q  <= '0;
            pass_q <= 1'b0;
          end
        end
        S_ACC: begin
          if (at_last) begin
            idx_q  <= '0;
            pass_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (at_last) begin
            cnt_q <= '0;
            sum_q <= '0;
            idx_q <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && take && close) begin
      q_q <= '0;
    end
    if (state_q == S_DIF) begin
      d_q <= d_d;
    end
    if (state_q == S_SQR) begin
      dsq_q <= DsqW'(ad) * DsqW'(ad);
    end
    if (state_q == S_ACC) begin
      q_q <= q_q + QW'(dsq_q);
    end
    if (state_q == S_MUL) begin
      zero_q <= (q_q == '0) || (dsq_q == '0);
    end
    if (state_q == S_EMIT) begin
      out_q.score      <= score_d;
      out_q.last_score <= at_last;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = out_q;

endmodule

// ----- hw/rtl/zsn_store.sv -----
// Sample store: one write port, one registered read port.
// Depends on nothing but its parameters.
module zsn_store #(
  parameter int Depth = 64,
  parameter int AddrW = 6,
  parameter int DataW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/zsn_rootdiv.sv -----
// Shared iterative unit: restoring division, then integer square root.
// Computes isqrt(floor(2^24 * nd2 / q)), one bit per cycle. Uses zsn_pkg.
module zsn_rootdiv #(
  parameter int NdW = 53,
  parameter int QW  = 53
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NdW-1:0]           nd2_i,
  input  logic [QW-1:0]            q_i,
  output logic                     done_o,
  output logic [zsn_pkg::RootW-1:0] root_o
);

  localparam int RemW  = QW + 1;
  localparam int QuoW  = zsn_pkg::QuoW;
  localparam int RootW = zsn_pkg::RootW;
  localparam int SremW = RootW + 2;
  localparam int StepW = $clog2(QuoW);
  localparam int HighW = NdW - (QuoW - zsn_pkg::LowShift);

  logic             run_q, sqrt_q, done_q;
  logic [StepW-1:0] step_q;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]  shf_q;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [SremW-1:0] srem_q, srem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RemW-1:0]  div_t;
  logic [SremW-1:0] sq_t, trial;
  logic             div_ge, sq_ge;

  // one division step and one square-root step
  always_comb begin
    div_t  = {rem_q[RemW-2:0], shf_q[QuoW-1]};
    div_ge = div_t >= {1'b0, q_i};
    rem_d  = div_ge ? div_t - {1'b0, q_i} : div_t;
    sq_t   = {srem_q[SremW-3:0], quo_q[QuoW-1 -: 2]};
    trial  = {root_q, 2'b01};
    sq_ge  = sq_t >= trial;
    srem_d = sq_ge ? sq_t - trial : sq_t;
    root_d = {root_q[RootW-2:0], sq_ge};
    quo_d  = {quo_q[QuoW-2:0], div_ge};
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      sqrt_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        sqrt_q <= 1'b0;
        step_q <= StepW'(QuoW - 1);
      end else if (run_q) begin
        if (!sqrt_q) begin
          if (step_q == '0) begin
            sqrt_q <= 1'b1;
            step_q <= StepW'(RootW - 1);
          end else begin
            step_q <= step_q - 1'b1;
          end
        end else begin
          if (step_q == '0) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= RemW'(nd2_i[NdW-1 -: HighW]);
      shf_q  <= {nd2_i[QuoW-zsn_pkg::LowShift-1:0], {zsn_pkg::LowShift{1'b0}}};
      quo_q  <= '0;
      srem_q <= '0;
      root_q <= '0;
    end else if (run_q) begin
      if (!sqrt_q) begin
        rem_q <= rem_d;
        shf_q <= {shf_q[QuoW-2:0], 1'b0};
        quo_q <= quo_d;
      end else begin
        srem_q <= srem_d;
        root_q <= root_d;
        quo_q  <= {quo_q[QuoW-3:0], 2'b00};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- hw/rtl/zsn_checker.sv -----
// Port-level checks for the column z-score normaliser, bound to the top.
// Depends on zsn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zsn_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input zsn_pkg::in_t  req_i,
  input logic          busy,
  input logic          res_valid_o,
  input zsn_pkg::out_t res_o
);

  // scores never come back to back
  `ZSN_ASSERT_NEXT(a_no_back_to_back, clk_i, rst_ni, res_valid_o, !res_valid_o)

  // a request with column_end set starts the scoring passes
  `ZSN_ASSERT_NEXT(a_close_busy, clk_i, rst_ni, start && !busy && req_i.column_end, busy)

  // the last score frees the block, any other keeps it busy
  `ZSN_ASSERT(a_last_free, clk_i, rst_ni, !(res_valid_o && res_o.last_score) || !busy)
  `ZSN_ASSERT(a_mid_busy, clk_i, rst_ni, !(res_valid_o && !res_o.last_score) || busy)

endmodule

bind column_zscore_normalizer zsn_checker u_zsn_checker (.*);
